// ===== rtl/character_lcd_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Character LCD controller - assertion macros
// Shared property wrappers for the controller's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CHARACTER_LCD_CONTROLLER_DEFINES_SVH
`define CHARACTER_LCD_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active
`define CLCD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define CLCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Character LCD controller package
// Sizes, instruction codes, sequencer states and address counter helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clcd_pkg;

    // Memory sizes
    localparam int DISPLAY_RAM_DEPTH = 128;
    localparam int GLYPH_RAM_DEPTH   = 64;
    localparam int DISP_AW           = $clog2(DISPLAY_RAM_DEPTH);
    localparam int GLYPH_AW          = $clog2(GLYPH_RAM_DEPTH);
    localparam int AC_W              = 7;

    localparam logic [7:0] DISP_LIMIT   = 8'(DISPLAY_RAM_DEPTH);
    localparam logic [7:0] GLYPH_MASK   = 8'(GLYPH_RAM_DEPTH - 1);

    // Address map and character constants
    localparam logic [7:0] TOP_ONE_LINE = 8'h4f;
    localparam logic [7:0] TOP_TWO_LINE = 8'h67;
    localparam logic [7:0] LINE1_END    = 8'h27;
    localparam logic [7:0] LINE2_START  = 8'h40;
    localparam logic [7:0] GAP_START    = 8'h28;
    localparam logic [6:0] SHIFT_SPAN   = 7'h50;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;

    // Decoded control-register instruction
    typedef enum logic [3:0] {
        INS_NONE,
        INS_SET_DDRAM,
        INS_SET_CGRAM,
        INS_FUNC_SET,
        INS_SHIFT,
        INS_DISP_CTRL,
        INS_ENTRY_MODE,
        INS_HOME,
        INS_CLEAR
    } instr_t;

    // Access sequencer
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    // Request from the sequencer to the RAM block
    typedef struct packed {
        logic           rd;
        logic           wr;
        logic           clr;
        logic           glyph;
        logic [AC_W-1:0] addr;
        logic [7:0]     wdata;
    } ram_req_t;

    // Highest set bit picks the instruction
    function automatic instr_t decode_instr(input logic [7:0] d);
        instr_t r;
        if (d[7])      r = INS_SET_DDRAM;
        else if (d[6]) r = INS_SET_CGRAM;
        else if (d[5]) r = INS_FUNC_SET;
        else if (d[4]) r = INS_SHIFT;
        else if (d[3]) r = INS_DISP_CTRL;
        else if (d[2]) r = INS_ENTRY_MODE;
        else if (d[1]) r = INS_HOME;
        else if (d[0]) r = INS_CLEAR;
        else           r = INS_NONE;
        return r;
    endfunction

    // Fold a raw counter value back into the legal address range
    function automatic logic [AC_W-1:0] fix_ac(input logic [7:0] v, input logic glyph,
                                               input logic two);
        logic [7:0] top;
        logic [7:0] r;
        top = two ? TOP_TWO_LINE : TOP_ONE_LINE;
        if (glyph)
            r = v & GLYPH_MASK;
        else if (v > top)
            r = v - (top + 8'd1);
        else if (two && v > LINE1_END && v < LINE2_START)
            r = v - GAP_START + LINE2_START;
        else
            r = v;
        return r[AC_W-1:0];
    endfunction

    // Step the counter by one in either direction
    function automatic logic [AC_W-1:0] step_ac(input logic [AC_W-1:0] ac, input logic dec,
                                                input logic glyph, input logic two);
        logic [7:0]      top;
        logic [AC_W-1:0] g;
        logic [AC_W-1:0] r;
        top = two ? TOP_TWO_LINE : TOP_ONE_LINE;
        g   = dec ? ac - 7'd1 : ac + 7'd1;
        if (glyph)
            r = g & GLYPH_MASK[AC_W-1:0];
        else if (dec && two && ac == LINE2_START[AC_W-1:0])
            r = LINE1_END[AC_W-1:0];
        else if (dec && ac == '0)
            r = top[AC_W-1:0];
        else if (dec)
            r = fix_ac({1'b0, ac} - 8'd1, 1'b0, two);
        else
            r = fix_ac({1'b0, ac} + 8'd1, 1'b0, two);
        return r;
    endfunction

    // Display shift, modulo the 80-column line
    function automatic logic [6:0] step_shift(input logic [6:0] s, input logic dec);
        logic [6:0] r;
        if (dec)
            r = (s == '0) ? SHIFT_SPAN - 7'd1 : s - 7'd1;
        else
            r = (s + 7'd1 >= SHIFT_SPAN) ? '0 : s + 7'd1;
        return r;
    endfunction

endpackage

// ===== rtl/character_lcd_controller.sv =====
// ----------------------------------------------------------------------------
// Character LCD controller
// Two-register bus front end: each input transaction is one control or data
// access, each output transaction reports read data and display status.
//
//   channel | dir | tdata                               | tuser
//   --------+-----+-------------------------------------+----------------------
//   s_axis  | in  | write_data                          | command, register_select
//   m_axis  | out | read_data, display_on, cursor_on,   | -
//           |     | blink_on, display_shift, two_line,  |
//           |     | tall_font                           |
//
// Each access steps through accept (ST_IDLE), RAM read (ST_READ), and execute
// and retire (ST_EXEC). The single-port RAM read and the read-modify-write of
// the address counter set these steps. Clear display takes the same path
// (valid bits drop at once). A held output stretches the execute state until the
// transaction drains. No clearing pass after reset: the block accepts at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "character_lcd_controller_defines.svh"

module character_lcd_controller
    import clcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] write_data
    input  logic [1:0]  s_axis_tuser,   // [0] command, [1] register_select
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] read_data, [8] display_on,
                                        // [9] cursor_on, [10] blink_on,
                                        // [17:11] display_shift, [18] two_line,
                                        // [19] tall_font, [23:20] zero
);

    state_t state_reg, state_next;

    // Latched access
    logic       cmd_reg;
    logic       rs_reg;
    logic [7:0] wd_reg;

    // Controller state
    logic [AC_W-1:0] ac_reg,        ac_next;
    logic            glyph_sel_reg, glyph_sel_next;
    logic            disp_en_reg,   disp_en_next;
    logic            cur_en_reg,    cur_en_next;
    logic            blink_reg,     blink_next;
    logic            auto_sh_reg,   auto_sh_next;
    logic            step_dec_reg,  step_dec_next;
    logic            two_line_reg,  two_line_next;
    logic            tall_reg,      tall_next;
    logic [6:0]      shift_reg,     shift_next;

    // Output holding register
    logic        m_valid_reg;
    logic [23:0] m_data_reg;
    logic [7:0]  rd_byte;

    ram_req_t   ram_req;
    logic [7:0] ram_rdata;
    instr_t     instr;
    logic       accept;
    logic       retire;

    // Terms for the checks
    logic       shift_ok;
    logic       glyph_ac_ok;
    logic       disp_ac_ok;
    logic [7:0] disp_top;
    logic       rd_started;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign retire        = (state_reg == ST_EXEC) && (!m_valid_reg || m_axis_tready);
    assign instr         = decode_instr(wd_reg);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    clcd_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rdata   (ram_rdata)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: if (retire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // RAM request: read in ST_READ, write or clear on retire
    always_comb begin
        ram_req.rd    = (state_reg == ST_READ);
        ram_req.wr    = retire && cmd_reg && rs_reg;
        ram_req.clr   = retire && cmd_reg && !rs_reg && (instr == INS_CLEAR);
        ram_req.glyph = glyph_sel_reg;
        ram_req.addr  = ac_reg;
        ram_req.wdata = wd_reg;
    end

    // Access execution
    always_comb begin
        ac_next        = ac_reg;
        glyph_sel_next = glyph_sel_reg;
        disp_en_next   = disp_en_reg;
        cur_en_next    = cur_en_reg;
        blink_next     = blink_reg;
        auto_sh_next   = auto_sh_reg;
        step_dec_next  = step_dec_reg;
        two_line_next  = two_line_reg;
        tall_next      = tall_reg;
        shift_next     = shift_reg;
        rd_byte        = 8'h00;

        if (cmd_reg && rs_reg) begin
            // data write
            ac_next = step_ac(ac_reg, step_dec_reg, glyph_sel_reg, two_line_reg);
            if (auto_sh_reg)
                shift_next = step_shift(shift_reg, step_dec_reg);
        end else if (!cmd_reg && rs_reg) begin
            // data read
            rd_byte = ram_rdata;
            ac_next = step_ac(ac_reg, step_dec_reg, glyph_sel_reg, two_line_reg);
        end else if (!cmd_reg) begin
            // control read: counter, busy clear
            rd_byte = {1'b0, ac_reg};
        end else begin
            case (instr)
                INS_SET_DDRAM: begin
                    glyph_sel_next = 1'b0;
                    ac_next        = fix_ac({1'b0, wd_reg[6:0]}, 1'b0, two_line_reg);
                end
                INS_SET_CGRAM: begin
                    glyph_sel_next = 1'b1;
                    ac_next        = {1'b0, wd_reg[5:0]};
                end
                INS_FUNC_SET: begin
                    two_line_next = wd_reg[3];
                    tall_next     = !wd_reg[3] && wd_reg[2];
                    ac_next       = fix_ac({1'b0, ac_reg}, glyph_sel_reg, wd_reg[3]);
                end
                INS_SHIFT: begin
                    if (wd_reg[3])
                        shift_next = step_shift(shift_reg, !wd_reg[2]);
                    else
                        ac_next = step_ac(ac_reg, !wd_reg[2], glyph_sel_reg, two_line_reg);
                end
                INS_DISP_CTRL: begin
                    disp_en_next = wd_reg[2];
                    cur_en_next  = wd_reg[1];
                    blink_next   = wd_reg[0];
                end
                INS_ENTRY_MODE: begin
                    step_dec_next = !wd_reg[1];
                    auto_sh_next  = wd_reg[0];
                end
                INS_HOME, INS_CLEAR: begin
                    ac_next        = '0;
                    glyph_sel_next = 1'b0;
                    step_dec_next  = 1'b0;
                    shift_next     = '0;
                end
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            ac_reg        <= '0;
            glyph_sel_reg <= 1'b0;
            disp_en_reg   <= 1'b0;
            cur_en_reg    <= 1'b0;
            blink_reg     <= 1'b0;
            auto_sh_reg   <= 1'b0;
            step_dec_reg  <= 1'b0;
            two_line_reg  <= 1'b0;
            tall_reg      <= 1'b0;
            shift_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (retire) begin
                m_valid_reg   <= 1'b1;
                ac_reg        <= ac_next;
                glyph_sel_reg <= glyph_sel_next;
                disp_en_reg   <= disp_en_next;
                cur_en_reg    <= cur_en_next;
                blink_reg     <= blink_next;
                auto_sh_reg   <= auto_sh_next;
                step_dec_reg  <= step_dec_next;
                two_line_reg  <= two_line_next;
                tall_reg      <= tall_next;
                shift_reg     <= shift_next;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_axis_tuser[0];
            rs_reg  <= s_axis_tuser[1];
            wd_reg  <= s_axis_tdata;
        end
        if (retire)
            m_data_reg <= {4'h0, tall_next, two_line_next, shift_next, blink_next,
                           cur_en_next, disp_en_next, rd_byte};
    end

    // Checks
    assign shift_ok    = shift_reg < SHIFT_SPAN;
    assign glyph_ac_ok = {1'b0, ac_reg} <= GLYPH_MASK;
    assign disp_top    = two_line_reg ? TOP_TWO_LINE : TOP_ONE_LINE;
    assign disp_ac_ok  = ({1'b0, ac_reg} <= disp_top) &&
                         !(two_line_reg && {1'b0, ac_reg} > LINE1_END &&
                           {1'b0, ac_reg} < LINE2_START);
    assign rd_started  = (state_reg == ST_READ) && !s_axis_tready;

    `CLCD_ASSERT_NOW(a_shift_range, aclk, aresetn, 1'b1, shift_ok, "display shift out of range")
    `CLCD_ASSERT_NOW(a_glyph_ac, aclk, aresetn, glyph_sel_reg, glyph_ac_ok, "bad glyph address")
    `CLCD_ASSERT_NOW(a_disp_ac, aclk, aresetn, !glyph_sel_reg, disp_ac_ok, "bad display address")
    `CLCD_ASSERT_NEXT(a_accept_seq, aclk, aresetn, accept, rd_started, "no RAM read after accept")

endmodule

// ===== rtl/clcd_ram.sv =====
// ----------------------------------------------------------------------------
// Character LCD RAM block
// Display RAM and glyph RAM with registered reads. Per-entry valid bits give
// the reset contents and let a display clear drop every display entry at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcd_ram
    import clcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  ram_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0]                   disp_mem [DISPLAY_RAM_DEPTH];
    logic [7:0]                   glyph_mem [GLYPH_RAM_DEPTH];
    logic [DISPLAY_RAM_DEPTH-1:0] disp_vld_reg;
    logic [GLYPH_RAM_DEPTH-1:0]   glyph_vld_reg;

    logic [DISP_AW-1:0]  disp_idx;
    logic [GLYPH_AW-1:0] glyph_idx;
    logic                disp_hit;
    logic                disp_we;
    logic                glyph_we;

    logic [7:0] disp_q_reg;
    logic [7:0] glyph_q_reg;
    logic       disp_vq_reg;
    logic       glyph_vq_reg;
    logic       hit_q_reg;
    logic       sel_q_reg;

    assign disp_idx  = req.addr[DISP_AW-1:0];
    assign glyph_idx = req.addr[GLYPH_AW-1:0];
    assign disp_hit  = {1'b0, req.addr} < DISP_LIMIT;
    assign disp_we   = req.wr && !req.glyph && disp_hit;
    assign glyph_we  = req.wr && req.glyph;

    // Storage arrays
    always_ff @(posedge aclk) begin
        if (disp_we)
            disp_mem[disp_idx] <= req.wdata;
        if (glyph_we)
            glyph_mem[glyph_idx] <= req.wdata;
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (req.rd) begin
            disp_q_reg   <= disp_mem[disp_idx];
            glyph_q_reg  <= glyph_mem[glyph_idx];
            disp_vq_reg  <= disp_vld_reg[disp_idx];
            glyph_vq_reg <= glyph_vld_reg[glyph_idx];
            hit_q_reg    <= disp_hit;
            sel_q_reg    <= req.glyph;
        end
    end

    // Written-entry tracking; clear drops display entries back to space
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disp_vld_reg  <= '0;
            glyph_vld_reg <= '0;
        end else begin
            if (req.clr)
                disp_vld_reg <= '0;
            else if (disp_we)
                disp_vld_reg[disp_idx] <= 1'b1;
            if (glyph_we)
                glyph_vld_reg[glyph_idx] <= 1'b1;
        end
    end

    // Unwritten entries read as their reset value
    always_comb begin
        if (sel_q_reg)
            rdata = glyph_vq_reg ? glyph_q_reg : 8'h00;
        else
            rdata = (hit_q_reg && disp_vq_reg) ? disp_q_reg : SPACE_CHAR;
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Character LCD controller testbench
// Sends control and data register accesses over the input stream and keeps a
// shadow copy of the controller (display RAM, glyph RAM, address counter,
// display flags, shift). Each returned status transaction is compared field by
// field against the oldest outstanding prediction. Directed checks of the
// instruction set and address wrap come first, then random bus sessions with
// random handshake stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import clcd_pkg::*;

    // Access kind as carried in tuser: [0] command, [1] register_select
    typedef enum logic [1:0] {
        ACC_CMD_READ   = 2'b00,
        ACC_CMD_WRITE  = 2'b01,
        ACC_DATA_READ  = 2'b10,
        ACC_DATA_WRITE = 2'b11
    } access_t;

    // Instruction opcodes, one per leading bit
    localparam logic [7:0] OP_NONE      = 8'h00;
    localparam logic [7:0] OP_CLEAR     = 8'h01;
    localparam logic [7:0] OP_HOME      = 8'h02;
    localparam logic [7:0] OP_ENTRY     = 8'h04;
    localparam logic [7:0] OP_DISPLAY   = 8'h08;
    localparam logic [7:0] OP_SHIFT     = 8'h10;
    localparam logic [7:0] OP_FUNCTION  = 8'h20;
    localparam logic [7:0] OP_SET_CGRAM = 8'h40;
    localparam logic [7:0] OP_SET_DDRAM = 8'h80;

    // Option bits inside the instructions
    localparam logic [7:0] ENTRY_AUTO    = 8'h01;
    localparam logic [7:0] ENTRY_INC     = 8'h02;
    localparam logic [7:0] BLINK_ON      = 8'h01;
    localparam logic [7:0] CURSOR_ON     = 8'h02;
    localparam logic [7:0] DISP_ON       = 8'h04;
    localparam logic [7:0] SHIFT_RIGHT   = 8'h04;
    localparam logic [7:0] SHIFT_SCREEN  = 8'h08;
    localparam logic [7:0] FUNC_TALL     = 8'h04;
    localparam logic [7:0] FUNC_TWO_LINE = 8'h08;

    localparam int CYCLE_LIMIT = 200000;

    // Status word, laid out as m_axis_tdata
    typedef struct packed {
        logic [3:0] pad;
        logic       tall_font;
        logic       two_line;
        logic [6:0] display_shift;
        logic       blink_on;
        logic       cursor_on;
        logic       display_on;
        logic [7:0] read_data;
    } lcd_status_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] write_data
    logic [1:0]  s_axis_tuser  = 2'b00;   // [0] command, [1] register_select
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [7:0] read_data, [8] display_on,
                                          // [9] cursor_on, [10] blink_on,
                                          // [17:11] display_shift, [18] two_line,
                                          // [19] tall_font, [23:20] zero

    character_lcd_controller dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the controller state
    logic [7:0] sh_ddram [DISPLAY_RAM_DEPTH];
    logic [7:0] sh_cgram [GLYPH_RAM_DEPTH];
    logic [6:0] sh_ac;
    logic       sh_cg;
    logic       sh_disp;
    logic       sh_cursor;
    logic       sh_blink;
    logic       sh_auto;
    logic       sh_dec;
    logic       sh_two;
    logic       sh_tall;
    logic [6:0] sh_shift;

    lcd_status_t pending_status [$];
    int          errors      = 0;
    int          cycle_count = 0;
    bit          calm        = 1'b0;   // no stalls on either side while set

    // Fold a raw display RAM address into the legal range
    function automatic logic [6:0] fold_addr(input logic [7:0] v);
        logic [7:0] top;
        logic [7:0] r;
        top = sh_two ? TOP_TWO_LINE : TOP_ONE_LINE;
        r   = v;
        if (sh_cg)
            r = v & GLYPH_MASK;
        else if (v > top)
            r = v - (top + 8'd1);
        else if (sh_two && v > LINE1_END && v < LINE2_START)
            r = LINE2_START + (v - GAP_START);
        return r[6:0];
    endfunction

    // Move the address counter by one
    function automatic void step_addr(input logic dec);
        logic [7:0] top;
        top = sh_two ? TOP_TWO_LINE : TOP_ONE_LINE;
        if (sh_cg) begin
            sh_ac = (dec ? sh_ac - 7'd1 : sh_ac + 7'd1) & GLYPH_MASK[6:0];
        end else if (!dec) begin
            sh_ac = fold_addr({1'b0, sh_ac} + 8'd1);
        end else if (sh_two && sh_ac == LINE2_START[6:0]) begin
            sh_ac = LINE1_END[6:0];
        end else if (sh_ac == 7'd0) begin
            sh_ac = top[6:0];
        end else begin
            sh_ac = fold_addr({1'b0, sh_ac} - 8'd1);
        end
    endfunction

    // Display shift wraps over the 80 columns of a line
    function automatic void nudge_shift(input logic dec);
        if (dec)
            sh_shift = (sh_shift == 7'd0) ? SHIFT_SPAN - 7'd1 : sh_shift - 7'd1;
        else
            sh_shift = (sh_shift + 7'd1 >= SHIFT_SPAN) ? 7'd0 : sh_shift + 7'd1;
    endfunction

    // Return home and clear share the counter and mode reset
    function automatic void go_home();
        sh_ac    = 7'd0;
        sh_cg    = 1'b0;
        sh_dec   = 1'b0;
        sh_shift = 7'd0;
    endfunction

    // Apply one access to the shadow state and return the status it reports
    function automatic lcd_status_t run_shadow_access(input access_t kind,
                                                      input logic [7:0] d);
        lcd_status_t r;
        int          i;
        r = '0;
        case (kind)
            ACC_DATA_WRITE: begin
                if (sh_cg)
                    sh_cgram[sh_ac[5:0]] = d;
                else if (int'(sh_ac) < DISPLAY_RAM_DEPTH)
                    sh_ddram[sh_ac] = d;
                step_addr(sh_dec);
                if (sh_auto)
                    nudge_shift(sh_dec);
            end
            ACC_DATA_READ: begin
                if (sh_cg)
                    r.read_data = sh_cgram[sh_ac[5:0]];
                else if (int'(sh_ac) < DISPLAY_RAM_DEPTH)
                    r.read_data = sh_ddram[sh_ac];
                else
                    r.read_data = SPACE_CHAR;
                step_addr(sh_dec);
            end
            ACC_CMD_READ: begin
                // busy flag always clear
                r.read_data = {1'b0, sh_ac};
            end
            default: begin
                // instruction picked by the highest set bit
                if (|(d & OP_SET_DDRAM)) begin
                    sh_cg = 1'b0;
                    sh_ac = fold_addr({1'b0, d[6:0]});
                end else if (|(d & OP_SET_CGRAM)) begin
                    sh_cg = 1'b1;
                    sh_ac = {1'b0, d[5:0]};
                end else if (|(d & OP_FUNCTION)) begin
                    sh_two  = |(d & FUNC_TWO_LINE);
                    sh_tall = !sh_two && |(d & FUNC_TALL);
                    sh_ac   = fold_addr({1'b0, sh_ac});
                end else if (|(d & OP_SHIFT)) begin
                    if (|(d & SHIFT_SCREEN))
                        nudge_shift(!(|(d & SHIFT_RIGHT)));
                    else
                        step_addr(!(|(d & SHIFT_RIGHT)));
                end else if (|(d & OP_DISPLAY)) begin
                    sh_disp   = |(d & DISP_ON);
                    sh_cursor = |(d & CURSOR_ON);
                    sh_blink  = |(d & BLINK_ON);
                end else if (|(d & OP_ENTRY)) begin
                    sh_dec  = !(|(d & ENTRY_INC));
                    sh_auto = |(d & ENTRY_AUTO);
                end else if (|(d & OP_HOME)) begin
                    go_home();
                end else if (|(d & OP_CLEAR)) begin
                    go_home();
                    for (i = 0; i < DISPLAY_RAM_DEPTH; i++)
                        sh_ddram[i] = SPACE_CHAR;
                end
            end
        endcase
        r.display_on    = sh_disp;
        r.cursor_on     = sh_cursor;
        r.blink_on      = sh_blink;
        r.display_shift = sh_shift;
        r.two_line      = sh_two;
        r.tall_font     = sh_tall;
        return r;
    endfunction

    // Present one access, wait for the transaction, then maybe idle the bus
    task automatic bus_access(input access_t kind, input logic [7:0] wd);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= wd;
        s_axis_tuser  <= kind;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        pending_status.push_back(run_shadow_access(kind, wd));
        @(negedge aclk);
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 31)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Hold the bus idle until every outstanding status has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver stalls
    always @(negedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 31);
    end

    // Status checker
    always @(posedge aclk) begin : status_check
        lcd_status_t got;
        lcd_status_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_status.size() == 0) begin
                $error("status transaction with no access outstanding: %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_status.pop_front();
                if (got.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                    errors++;
                end
                if (got.display_on !== want.display_on) begin
                    $error("display_on: expected %b, got %b", want.display_on, got.display_on);
                    errors++;
                end
                if (got.cursor_on !== want.cursor_on) begin
                    $error("cursor_on: expected %b, got %b", want.cursor_on, got.cursor_on);
                    errors++;
                end
                if (got.blink_on !== want.blink_on) begin
                    $error("blink_on: expected %b, got %b", want.blink_on, got.blink_on);
                    errors++;
                end
                if (got.display_shift !== want.display_shift) begin
                    $error("display_shift: expected %0d, got %0d",
                           want.display_shift, got.display_shift);
                    errors++;
                end
                if (got.two_line !== want.two_line) begin
                    $error("two_line: expected %b, got %b", want.two_line, got.two_line);
                    errors++;
                end
                if (got.tall_font !== want.tall_font) begin
                    $error("tall_font: expected %b, got %b", want.tall_font, got.tall_font);
                    errors++;
                end
                if (got.pad !== want.pad) begin
                    $error("pad: expected %h, got %h", want.pad, got.pad);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Counter and RAM contents right after reset
    task automatic test_power_on_state();
        bus_access(ACC_CMD_READ, 8'h00);
        bus_access(ACC_DATA_READ, 8'hff);
    endtask

    // Display, cursor and blink flags
    task automatic test_display_flags();
        bus_access(ACC_CMD_WRITE, OP_DISPLAY | DISP_ON | CURSOR_ON | BLINK_ON);
        bus_access(ACC_CMD_WRITE, OP_DISPLAY | CURSOR_ON);
    endtask

    // Tall font is refused in two-line mode
    task automatic test_function_set();
        bus_access(ACC_CMD_WRITE, OP_FUNCTION | FUNC_TWO_LINE | FUNC_TALL);
        bus_access(ACC_CMD_WRITE, OP_FUNCTION | FUNC_TALL);
    endtask

    // One-line and two-line wrap of the address counter
    task automatic test_address_wrap();
        bus_access(ACC_CMD_WRITE, OP_SET_DDRAM | 8'h7f);
        bus_access(ACC_CMD_WRITE, OP_SET_DDRAM | TOP_ONE_LINE);
        bus_access(ACC_DATA_WRITE, 8'hff);
        bus_access(ACC_CMD_WRITE, OP_ENTRY);
        bus_access(ACC_DATA_READ, 8'h00);
        bus_access(ACC_CMD_WRITE, OP_FUNCTION | FUNC_TWO_LINE);
        bus_access(ACC_CMD_WRITE, OP_SET_DDRAM | LINE1_END);
        bus_access(ACC_CMD_WRITE, OP_ENTRY | ENTRY_INC);
        bus_access(ACC_DATA_WRITE, 8'h00);
        bus_access(ACC_CMD_WRITE, OP_SHIFT);
        bus_access(ACC_CMD_WRITE, OP_SET_DDRAM | TOP_TWO_LINE);
        bus_access(ACC_DATA_READ, 8'h00);
        bus_access(ACC_CMD_READ, 8'h00);
    endtask

    // Glyph RAM write, wrap at its top and read back
    task automatic test_glyph_ram();
        bus_access(ACC_CMD_WRITE, OP_SET_CGRAM | 8'h3f);
        bus_access(ACC_DATA_WRITE, 8'ha5);
        bus_access(ACC_CMD_WRITE, OP_SET_CGRAM | 8'h3f);
        bus_access(ACC_DATA_READ, 8'h00);
    endtask

    // Display shift both ways across zero, then entry auto-shift
    task automatic test_display_shift();
        bus_access(ACC_CMD_WRITE, OP_SHIFT | SHIFT_SCREEN);
        bus_access(ACC_CMD_WRITE, OP_SHIFT | SHIFT_SCREEN | SHIFT_RIGHT);
        bus_access(ACC_CMD_WRITE, OP_ENTRY | ENTRY_INC | ENTRY_AUTO);
        bus_access(ACC_DATA_WRITE, 8'h5a);
    endtask

    // Return home, clear display and the all-zero byte that does nothing
    task automatic test_home_and_clear();
        bus_access(ACC_CMD_WRITE, OP_HOME);
        bus_access(ACC_CMD_WRITE, OP_CLEAR);
        bus_access(ACC_DATA_READ, 8'h00);
        bus_access(ACC_CMD_WRITE, OP_NONE);
    endtask

    // Random bus sessions: text bursts, readback, glyph edits, instructions, noise
    task automatic test_random_sessions(input int n_items);
        int         sent;
        int         burst;
        int         k;
        int         sel;
        int         next_drain;
        logic [7:0] d;
        sent       = 0;
        next_drain = $urandom_range(60, 200);
        while (sent < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                bus_access(ACC_CMD_WRITE, OP_SET_DDRAM | 8'($urandom_range(0, 127)));
                burst = $urandom_range(1, 8);
                repeat (burst) bus_access(ACC_DATA_WRITE, 8'($urandom_range(0, 255)));
                sent += burst + 1;
            end else if (sel < 50) begin
                bus_access(ACC_CMD_WRITE, OP_SET_DDRAM | 8'($urandom_range(0, 127)));
                burst = $urandom_range(1, 8);
                repeat (burst) bus_access(ACC_DATA_READ, 8'($urandom_range(0, 255)));
                sent += burst + 1;
            end else if (sel < 60) begin
                bus_access(ACC_CMD_WRITE, OP_SET_CGRAM | 8'($urandom_range(0, 63)));
                burst = $urandom_range(1, 8);
                repeat (burst)
                    bus_access($urandom_range(0, 1) ? ACC_DATA_WRITE : ACC_DATA_READ,
                               8'($urandom_range(0, 255)));
                sent += burst + 1;
            end else if (sel < 78) begin
                k = $urandom_range(0, 7);
                d = (8'h01 << k) | (8'($urandom_range(0, 255)) & ((8'h01 << k) - 8'h01));
                bus_access(ACC_CMD_WRITE, d);
                sent++;
            end else if (sel < 88) begin
                bus_access(ACC_CMD_READ, 8'($urandom_range(0, 255)));
                sent++;
            end else begin
                bus_access(access_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                sent++;
            end
            // let the pipeline run dry now and then
            if (sent >= next_drain) begin
                drain_results();
                next_drain = sent + $urandom_range(60, 200);
            end
        end
    endtask

    // A stretch with no stalls on either side
    task automatic test_back_to_back(input int n_items);
        calm = 1'b1;
        test_random_sessions(n_items);
        calm = 1'b0;
    endtask

    initial begin : main
        int i;
        for (i = 0; i < DISPLAY_RAM_DEPTH; i++)
            sh_ddram[i] = SPACE_CHAR;
        for (i = 0; i < GLYPH_RAM_DEPTH; i++)
            sh_cgram[i] = 8'h00;
        sh_ac     = 7'd0;
        sh_cg     = 1'b0;
        sh_disp   = 1'b0;
        sh_cursor = 1'b0;
        sh_blink  = 1'b0;
        sh_auto   = 1'b0;
        sh_dec    = 1'b0;
        sh_two    = 1'b0;
        sh_tall   = 1'b0;
        sh_shift  = 7'd0;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_power_on_state();
        test_display_flags();
        test_function_set();
        test_address_wrap();
        test_glyph_ram();
        test_display_shift();
        test_home_and_clear();
        drain_results();
        test_random_sessions(700);
        test_back_to_back(130);
        test_random_sessions(120);

        drain_results();
        repeat (16) @(posedge aclk);
        if (errors == 0 && pending_status.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
